>>> hw/rtl/fca_pkg.sv
// ----------------------------------------------------------------------------
// fca_pkg
// Types, constants and helpers shared by the chain allocator modules.
// ----------------------------------------------------------------------------
package fca_pkg;

    localparam int NUM_BLOCKS      = 256;
    localparam int ROOT_ENTRIES    = 16;
    localparam int RESERVED_BLOCKS = 11;
    localparam int NAME_BITS       = 48;

    localparam int KEY_W  = 48;
    localparam int BLK_W  = 8;
    localparam int AW     = $clog2(NUM_BLOCKS);
    localparam int TW     = AW + 1;
    localparam int IW     = $clog2(ROOT_ENTRIES);
    localparam int STEP_W = AW + 1;
    localparam int FIRST_FREE = RESERVED_BLOCKS + 2;
    localparam logic [BLK_W-1:0] FREE_HEAD_RST =
        (FIRST_FREE < NUM_BLOCKS) ? BLK_W'(FIRST_FREE) : '0;

    typedef enum logic [2:0] {
        OP_CREATE = 3'd0,
        OP_REMOVE = 3'd1,
        OP_FIRST  = 3'd2,
        OP_APPEND = 3'd3,
        OP_DELETE = 3'd4,
        OP_NEXT   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_FOUND   = 3'd1,
        ST_EXISTS      = 3'd2,
        ST_DIR_FULL    = 3'd3,
        ST_NOT_EMPTY   = 3'd4,
        ST_NO_SPACE    = 3'd5,
        ST_NOT_IN_FILE = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DISPATCH,
        S_WALK_RD,
        S_WALK_WAIT,
        S_LINK_WR,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_CHK,
        S_CHK_WAIT,
        S_BLK_WAIT,
        S_PUSH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                 set_used;
        logic                 clr_used;
        logic                 set_first;
        logic [IW-1:0]        idx;
        logic [KEY_W-1:0]     name;
        logic [BLK_W-1:0]     first;
    } dir_cmd_t;

    typedef struct packed {
        logic                 rd_en;
        logic [AW-1:0]        rd_addr;
        logic                 we;
        logic [AW-1:0]        waddr;
        logic [TW-1:0]        wdata;
    } tbl_cmd_t;

    // formatted content of a table entry right after reset
    function automatic logic [TW-1:0] fmt_entry(input logic [AW-1:0] addr);
        logic [TW-1:0] v;
        if (int'(addr) < FIRST_FREE)
            v = TW'(NUM_BLOCKS);
        else if (int'(addr) + 1 < NUM_BLOCKS)
            v = TW'(addr) + TW'(1);
        else
            v = '0;
        return v;
    endfunction

    // nonzero and below NUM_BLOCKS
    function automatic logic blk_ok(input logic [TW-1:0] b);
        return (b != '0) && !b[TW-1];
    endfunction

endpackage

>>> hw/rtl/fca_table.sv
// ----------------------------------------------------------------------------
// fca_table
// Allocation table memory: one read and one write port, registered read,
// per-entry valid bits so unwritten entries read as the formatted value.
// ----------------------------------------------------------------------------
module fca_table (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fca_pkg::tbl_cmd_t       cmd,
    output logic [fca_pkg::TW-1:0]  rdata
);
    import fca_pkg::*;

    logic [TW-1:0]         mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] vld_reg;
    logic [TW-1:0]         mem_q_reg;
    logic [TW-1:0]         fmt_q_reg;
    logic                  vld_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (cmd.we)
        begin
            vld_reg[cmd.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[cmd.waddr] <= cmd.wdata;
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[cmd.rd_addr];
            fmt_q_reg <= fmt_entry(cmd.rd_addr);
            vld_q_reg <= vld_reg[cmd.rd_addr];
        end
    end

    assign rdata = vld_q_reg ? mem_q_reg : fmt_q_reg;

endmodule

>>> hw/rtl/fca_dir.sv
// ----------------------------------------------------------------------------
// fca_dir
// Root directory: names, in-use bits and first blocks, with the shared name
// comparator used by the sequential scan.
// ----------------------------------------------------------------------------
module fca_dir (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fca_pkg::dir_cmd_t          cmd,
    input  logic [fca_pkg::IW-1:0]     scan_idx,
    input  logic [fca_pkg::KEY_W-1:0]  key,
    input  logic [fca_pkg::IW-1:0]     slot,
    output logic                       hit,
    output logic                       used,
    output logic [fca_pkg::BLK_W-1:0]  first
);
    import fca_pkg::*;

    logic [KEY_W-1:0]        names [ROOT_ENTRIES];
    logic [ROOT_ENTRIES-1:0] used_reg;
    logic [BLK_W-1:0]        first_reg [ROOT_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (cmd.set_used)
        begin
            names[cmd.idx] <= cmd.name;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int i = 0; i < ROOT_ENTRIES; i++)
            begin
                first_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.set_used)
            begin
                used_reg[cmd.idx] <= 1'b1;
            end
            else if (cmd.clr_used)
            begin
                used_reg[cmd.idx] <= 1'b0;
            end
            if (cmd.set_first)
            begin
                first_reg[cmd.idx] <= cmd.first;
            end
        end
    end

    assign used  = used_reg[scan_idx];
    assign hit   = used_reg[scan_idx] &&
                   (names[scan_idx][NAME_BITS-1:0] == key[NAME_BITS-1:0]);
    assign first = first_reg[slot];

endmodule

>>> hw/rtl/fat_chain_allocator_unit.sv
// ----------------------------------------------------------------------------
// fat_chain_allocator_unit
// File allocation table with free chain and root directory, one request at
// a time under a small sequencer.
// ----------------------------------------------------------------------------
// A request is taken only while the unit is idle and produces exactly one
// result word. Every request first scans the directory, one entry a cycle.
// Create, remove and first-block then finish from the dispatch state. Append
// walks the file's chain through the table, a read state and a wait state per
// block (single read port, registered read), then links the last block to the
// free head and pops the free head. Delete and next walk the chain the same
// way up to the named block, then unlink it or return its successor. The
// table read port sets the pace. The table comes out of reset formatted, with
// no clearing pass.
// ----------------------------------------------------------------------------
module fat_chain_allocator_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 op,
    input  logic [47:0]                file_key,
    input  logic [7:0]                 block_num,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 status,
    output logic [7:0]                 block_out
);
    import fca_pkg::*;

    state_t            state_reg, state_next;
    logic [2:0]        op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [BLK_W-1:0]  blk_reg;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     slot_reg, slot_next;
    logic [IW-1:0]     fslot_reg, fslot_next;
    logic              found_reg, found_next;
    logic              fok_reg, fok_next;
    logic [TW-1:0]     cur_reg, cur_next;
    logic [BLK_W-1:0]  prev_reg, prev_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [BLK_W-1:0]  head_reg, head_next;
    status_t           st_reg, st_next;
    logic [BLK_W-1:0]  bout_reg, bout_next;
    logic              ov_reg, ov_next;
    logic [2:0]        ost_reg, ost_next;
    logic [BLK_W-1:0]  obo_reg, obo_next;

    dir_cmd_t          dcmd;
    tbl_cmd_t          tcmd;
    logic              dhit, dused;
    logic [BLK_W-1:0]  dfirst;
    logic [TW-1:0]     trd;

    fca_dir u_dir (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dcmd),
        .scan_idx (idx_reg),
        .key      (key_reg),
        .slot     (slot_reg),
        .hit      (dhit),
        .used     (dused),
        .first    (dfirst)
    );

    fca_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (tcmd),
        .rdata (trd)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign status    = ost_reg;
    assign block_out = obo_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= op;
            key_reg <= file_key;
            blk_reg <= block_num;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            slot_reg  <= '0;
            fslot_reg <= '0;
            found_reg <= 1'b0;
            fok_reg   <= 1'b0;
            cur_reg   <= '0;
            prev_reg  <= '0;
            steps_reg <= '0;
            head_reg  <= FREE_HEAD_RST;
            st_reg    <= ST_OK;
            bout_reg  <= '0;
            ov_reg    <= 1'b0;
            ost_reg   <= '0;
            obo_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            slot_reg  <= slot_next;
            fslot_reg <= fslot_next;
            found_reg <= found_next;
            fok_reg   <= fok_next;
            cur_reg   <= cur_next;
            prev_reg  <= prev_next;
            steps_reg <= steps_next;
            head_reg  <= head_next;
            st_reg    <= st_next;
            bout_reg  <= bout_next;
            ov_reg    <= ov_next;
            ost_reg   <= ost_next;
            obo_reg   <= obo_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        fslot_next = fslot_reg;
        found_next = found_reg;
        fok_next   = fok_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        steps_next = steps_reg;
        head_next  = head_reg;
        st_next    = st_reg;
        bout_next  = bout_reg;
        ov_next    = ov_reg;
        ost_next   = ost_reg;
        obo_next   = obo_reg;
        dcmd       = '0;
        dcmd.idx   = slot_reg;
        dcmd.name  = key_reg;
        tcmd       = '0;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    fok_next   = 1'b0;
                    st_next    = ST_OK;
                    bout_next  = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (dhit && !found_reg)
                begin
                    found_next = 1'b1;
                    slot_next  = idx_reg;
                end
                if (!dused && !fok_reg)
                begin
                    fok_next   = 1'b1;
                    fslot_next = idx_reg;
                end
                if (int'(idx_reg) == ROOT_ENTRIES - 1)
                begin
                    state_next = S_DISPATCH;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_DISPATCH:
            begin
                state_next = S_DONE;
                cur_next   = TW'(dfirst);
                prev_next  = '0;
                steps_next = '0;
                case (op_reg)
                    OP_CREATE:
                    begin
                        if (found_reg)
                        begin
                            st_next = ST_EXISTS;
                        end
                        else if (fok_reg)
                        begin
                            dcmd.idx       = fslot_reg;
                            dcmd.set_used  = 1'b1;
                            dcmd.set_first = 1'b1;
                            dcmd.first     = '0;
                        end
                        else
                        begin
                            st_next = ST_DIR_FULL;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!found_reg)
                            st_next = ST_NOT_FOUND;
                        else if (dfirst != '0)
                            st_next = ST_NOT_EMPTY;
                        else
                            dcmd.clr_used = 1'b1;
                    end
                    OP_FIRST:
                    begin
                        if (!found_reg)
                            st_next = ST_NOT_FOUND;
                        else
                            bout_next = dfirst;
                    end
                    OP_APPEND:
                    begin
                        if (!blk_ok(TW'(head_reg)))
                        begin
                            st_next = ST_NO_SPACE;
                        end
                        else if (!found_reg)
                        begin
                            st_next = ST_NOT_FOUND;
                        end
                        else if (!blk_ok(TW'(dfirst)))
                        begin
                            dcmd.set_first = 1'b1;
                            dcmd.first     = head_reg;
                            state_next     = S_HEAD_RD;
                        end
                        else
                        begin
                            state_next = S_WALK_RD;
                        end
                    end
                    OP_DELETE, OP_NEXT:
                    begin
                        if (!found_reg)
                            st_next = ST_NOT_FOUND;
                        else
                            state_next = S_CHK;
                    end
                    default:
                    begin
                    end
                endcase
            end
            // append: find the last block of the chain
            S_WALK_RD:
            begin
                if (int'(steps_reg) == NUM_BLOCKS)
                begin
                    state_next = S_LINK_WR;
                end
                else
                begin
                    tcmd.rd_en   = 1'b1;
                    tcmd.rd_addr = cur_reg[AW-1:0];
                    state_next   = S_WALK_WAIT;
                end
            end
            S_WALK_WAIT:
            begin
                if (!blk_ok(trd))
                begin
                    state_next = S_LINK_WR;
                end
                else
                begin
                    cur_next   = trd;
                    steps_next = steps_reg + STEP_W'(1);
                    state_next = S_WALK_RD;
                end
            end
            S_LINK_WR:
            begin
                tcmd.we    = 1'b1;
                tcmd.waddr = cur_reg[AW-1:0];
                tcmd.wdata = TW'(head_reg);
                state_next = S_HEAD_RD;
            end
            S_HEAD_RD:
            begin
                tcmd.rd_en   = 1'b1;
                tcmd.rd_addr = AW'(head_reg);
                state_next   = S_HEAD_WAIT;
            end
            S_HEAD_WAIT:
            begin
                head_next  = blk_ok(trd) ? trd[BLK_W-1:0] : '0;
                tcmd.we    = 1'b1;
                tcmd.waddr = AW'(head_reg);
                tcmd.wdata = '0;
                bout_next  = head_reg;
                state_next = S_DONE;
            end
            // delete / next: membership walk up to the named block
            S_CHK:
            begin
                if (int'(steps_reg) == NUM_BLOCKS || !blk_ok(cur_reg))
                begin
                    st_next    = ST_NOT_IN_FILE;
                    state_next = S_DONE;
                end
                else
                begin
                    tcmd.rd_en   = 1'b1;
                    tcmd.rd_addr = cur_reg[AW-1:0];
                    if (cur_reg == TW'(blk_reg))
                        state_next = S_BLK_WAIT;
                    else
                        state_next = S_CHK_WAIT;
                end
            end
            S_CHK_WAIT:
            begin
                prev_next  = cur_reg[BLK_W-1:0];
                cur_next   = trd;
                steps_next = steps_reg + STEP_W'(1);
                state_next = S_CHK;
            end
            S_BLK_WAIT:
            begin
                if (op_reg == OP_NEXT)
                begin
                    bout_next  = trd[BLK_W-1:0];
                    state_next = S_DONE;
                end
                else
                begin
                    if (prev_reg == '0)
                    begin
                        dcmd.set_first = 1'b1;
                        dcmd.first     = trd[BLK_W-1:0];
                    end
                    else
                    begin
                        tcmd.we    = 1'b1;
                        tcmd.waddr = AW'(prev_reg);
                        tcmd.wdata = trd;
                    end
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                tcmd.we    = 1'b1;
                tcmd.waddr = AW'(blk_reg);
                tcmd.wdata = TW'(head_reg);
                head_next  = blk_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    obo_next   = bout_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg == '0 || int'(head_reg) >= FIRST_FREE)
        else $error("free head points into reserved area");

    a_err_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> block_out == '0)
        else $error("error result carries a block");

    a_no_rsv_write: assert property (@(posedge clk) disable iff (!rst_n)
        tcmd.we |-> int'(tcmd.waddr) >= FIRST_FREE)
        else $error("table write to reserved block");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_SCAN && idx_reg == '0)
        else $error("accepted word did not start a scan");
`endif

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the chain allocator: directed table of requests,
// then random file-system traffic, all checked against a behavioral model.
// ----------------------------------------------------------------------------
module tb;
    import fca_pkg::*;

    localparam int NBLK = NUM_BLOCKS;
    localparam int NDIR = ROOT_ENTRIES;
    localparam logic [47:0] EMPTY_NAME = 48'h585858585858;

    typedef struct packed {
        logic [2:0]  op;
        logic [47:0] key;
        logic [7:0]  blk;
    } req_t;

    typedef struct packed {
        logic [2:0] st;
        logic [7:0] blk;
    } resp_t;

    typedef struct {
        req_t  rq;
        logic  known;
        resp_t rs;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  op = '0;
    logic [47:0] file_key = '0;
    logic [7:0]  block_num = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  status;
    logic [7:0]  block_out;

    fat_chain_allocator_unit dut (.*);

    always #4 clk = ~clk;

    // model of the table
    logic [47:0] m_name  [NDIR];
    logic        m_used  [NDIR];
    logic [7:0]  m_first [NDIR];
    logic [8:0]  m_tbl   [NBLK];
    logic [7:0]  m_free;

    resp_t resp_q[$];
    row_t  rows[$];
    int    errors = 0;
    bit    stim_done = 0;
    logic [47:0] names[8];

    function automatic void add_row(row_t w);
        rows.insert(rows.size(), w);
    endfunction

    function automatic void queue_word(resp_t p);
        resp_q.insert(resp_q.size(), p);
    endfunction

    function automatic bit good_blk(logic [8:0] b);
        return b != 0 && b < NBLK;
    endfunction

    function automatic int lookup(logic [47:0] k);
        for (int i = 0; i < NDIR; i++)
            if (m_used[i] && m_name[i] == k) return i;
        return -1;
    endfunction

    function automatic bit chain_has(int s, logic [7:0] blk, output logic [7:0] pred);
        logic [8:0] b;
        logic [7:0] prev;
        b = {1'b0, m_first[s]};
        prev = 0;
        pred = 0;
        for (int n = 0; n < NBLK && good_blk(b); n++)
        begin
            if (b[7:0] == blk)
            begin
                pred = prev;
                return 1;
            end
            prev = b[7:0];
            b = m_tbl[b[7:0]];
        end
        return 0;
    endfunction

    function automatic void format_table();
        for (int i = 0; i < NDIR; i++)
        begin
            m_name[i] = EMPTY_NAME;
            m_used[i] = 0;
            m_first[i] = 0;
        end
        for (int i = 0; i < NBLK; i++)
            m_tbl[i] = (i < FIRST_FREE) ? 9'(NBLK) : (i + 1 < NBLK) ? 9'(i + 1) : 9'd0;
        m_free = FREE_HEAD_RST;
    endfunction

    function automatic resp_t fat_request(req_t r);
        resp_t      rs;
        int         s;
        logic [7:0] pred, a, b;
        logic [8:0] n;
        rs.st = ST_OK;
        rs.blk = 0;
        s = lookup(r.key);
        case (r.op)
            OP_CREATE:
                if (s >= 0) rs.st = ST_EXISTS;
                else
                begin
                    rs.st = ST_DIR_FULL;
                    for (int i = 0; i < NDIR; i++)
                        if (!m_used[i])
                        begin
                            m_used[i] = 1;
                            m_name[i] = r.key;
                            m_first[i] = 0;
                            rs.st = ST_OK;
                            break;
                        end
                end
            OP_REMOVE:
                if (s < 0) rs.st = ST_NOT_FOUND;
                else if (m_first[s] != 0) rs.st = ST_NOT_EMPTY;
                else
                begin
                    m_used[s] = 0;
                    m_name[s] = EMPTY_NAME;
                end
            OP_FIRST:
                if (s < 0) rs.st = ST_NOT_FOUND;
                else rs.blk = m_first[s];
            OP_APPEND:
            begin
                a = m_free;
                if (!good_blk({1'b0, a})) rs.st = ST_NO_SPACE;
                else if (s < 0) rs.st = ST_NOT_FOUND;
                else
                begin
                    if (!good_blk({1'b0, m_first[s]})) m_first[s] = a;
                    else
                    begin
                        b = m_first[s];
                        for (int k = 0; k < NBLK; k++)
                        begin
                            n = m_tbl[b];
                            if (!good_blk(n)) break;
                            b = n[7:0];
                        end
                        m_tbl[b] = {1'b0, a};
                    end
                    m_free = good_blk(m_tbl[a]) ? m_tbl[a][7:0] : 8'd0;
                    m_tbl[a] = 0;
                    rs.blk = a;
                end
            end
            OP_DELETE:
                if (s < 0) rs.st = ST_NOT_FOUND;
                else if (!chain_has(s, r.blk, pred)) rs.st = ST_NOT_IN_FILE;
                else
                begin
                    if (pred == 0) m_first[s] = m_tbl[r.blk][7:0];
                    else m_tbl[pred] = m_tbl[r.blk];
                    m_tbl[r.blk] = {1'b0, m_free};
                    m_free = r.blk;
                end
            OP_NEXT:
                if (s < 0) rs.st = ST_NOT_FOUND;
                else if (!chain_has(s, r.blk, pred)) rs.st = ST_NOT_IN_FILE;
                else rs.blk = m_tbl[r.blk][7:0];
            default: ;
        endcase
        return rs;
    endfunction

    // valid drops only when an idle gap is drawn
    task automatic send(req_t r, logic known, resp_t want);
        resp_t p;
        int    d;
        d = $urandom_range(0, 3);
        if (d != 0)
        begin
            in_valid <= 1'b0;
            repeat (d) @(negedge clk);
        end
        p = fat_request(r);
        if (known && p != want)
        begin
            errors++;
            if (errors <= 10)
                $display("table row mismatch op=%0d: typed %h model %h", r.op, want, p);
        end
        queue_word(p);
        in_valid <= 1'b1;
        op <= r.op;
        file_key <= r.key;
        block_num <= r.blk;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    function automatic req_t mk(logic [2:0] o, logic [47:0] k, logic [7:0] b);
        req_t r;
        r.op = o;
        r.key = k;
        r.blk = b;
        return r;
    endfunction

    // receiver: random stall per word
    initial
    begin
        resp_t e;
        int    d;
        forever
        begin
            @(negedge clk);
            d = $urandom_range(0, 3);
            if (d != 0)
            begin
                out_ready <= 1'b0;
                repeat (d) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            if (resp_q.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected word st=%0d blk=%0d", status, block_out);
            end
            else
            begin
                e = resp_q.pop_front();
                if (status !== e.st || block_out !== e.blk)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp st=%0d blk=%0d got st=%0d blk=%0d",
                                 e.st, e.blk, status, block_out);
                end
            end
        end
    end

    initial
    begin
        row_t        w;
        req_t        r;
        logic [47:0] k;
        int          u;
        format_table();
        names[0] = 48'h46494C453030;
        names[1] = EMPTY_NAME;
        names[2] = '0;
        names[3] = '1;
        for (int i = 4; i < 8; i++) names[i] = {$urandom, 16'($urandom)};

        // op, key, block, typed?, status, block
        add_row('{mk(OP_FIRST,  names[0], 0),   1, '{ST_NOT_FOUND, 0}});
        add_row('{mk(OP_CREATE, names[0], 0),   1, '{ST_OK, 0}});
        add_row('{mk(OP_CREATE, names[0], 0),   1, '{ST_EXISTS, 0}});
        add_row('{mk(OP_FIRST,  names[0], 0),   1, '{ST_OK, 0}});
        add_row('{mk(OP_APPEND, names[0], 0),   1, '{ST_OK, 8'(FIRST_FREE)}});
        add_row('{mk(OP_APPEND, names[0], 0),   1, '{ST_OK, 8'(FIRST_FREE + 1)}});
        add_row('{mk(OP_REMOVE, names[0], 0),   1, '{ST_NOT_EMPTY, 0}});
        add_row('{mk(OP_NEXT,   names[0], 13),  1, '{ST_OK, 14}});
        add_row('{mk(OP_NEXT,   names[0], 0),   1, '{ST_NOT_IN_FILE, 0}});
        add_row('{mk(OP_NEXT,   names[0], 255), 1, '{ST_NOT_IN_FILE, 0}});
        add_row('{mk(OP_DELETE, names[0], 200), 1, '{ST_NOT_IN_FILE, 0}});
        add_row('{mk(OP_DELETE, names[2], 13),  1, '{ST_NOT_FOUND, 0}});
        add_row('{mk(OP_APPEND, names[3], 0),   1, '{ST_NOT_FOUND, 0}});
        add_row('{mk(OP_CREATE, names[1], 0),   1, '{ST_OK, 0}});
        add_row('{mk(OP_CREATE, names[2], 0),   1, '{ST_OK, 0}});
        add_row('{mk(OP_CREATE, names[3], 0),   1, '{ST_OK, 0}});
        add_row('{mk(OP_DELETE, names[0], 13),  0, '{ST_OK, 0}});
        add_row('{mk(OP_FIRST,  names[0], 0),   0, '{ST_OK, 0}});
        add_row('{mk(OP_APPEND, names[1], 0),   0, '{ST_OK, 0}});
        add_row('{mk(3'd6,      names[0], 7),   1, '{ST_OK, 0}});
        add_row('{mk(3'd7,      names[3], 255), 1, '{ST_OK, 0}});
        add_row('{mk(OP_REMOVE, names[2], 0),   1, '{ST_OK, 0}});
        add_row('{mk(OP_REMOVE, names[2], 0),   1, '{ST_NOT_FOUND, 0}});

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (rows[i])
        begin
            w = rows[i];
            send(w.rq, w.known, w.rs);
        end

        // fill directory and exhaust free space once so full/no-space are hit
        for (int i = 0; i < NDIR + 1; i++)
            send(mk(OP_CREATE, {32'h46303030, 16'(i)}, 0), 0, '0);
        for (int i = 0; i < NBLK; i++)
            send(mk(OP_APPEND, {32'h46303030, 16'(i % 3)}, 0), 0, '0);

        for (int n = 0; n < 330; n++)
        begin
            u = $urandom_range(0, 99);
            if (u < 85) k = (u < 45) ? {32'h46303030, 16'($urandom_range(0, 19))}
                                     : names[$urandom_range(0, 7)];
            else k = {$urandom, 16'($urandom)};
            r.key = k;
            r.op = (u % 17 == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
            // blocks mostly near the allocated region
            r.blk = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
            if (r.op == OP_DELETE && u < 20)
            begin
                // delete four consecutive block numbers, then remove the file, so directory slots churn
                for (int j = 0; j < 4; j++) send(mk(OP_DELETE, k, r.blk + 8'(j)), 0, '0);
                r.op = OP_REMOVE;
            end
            send(r, 0, '0);
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        wait (resp_q.size() == 0);
        repeat (600) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("Verification failed");
        $finish;
    end
endmodule
